// ===== design/assert_macros.svh =====
// Assertion macros shared by the alarm table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/tda_pkg.sv =====
// Types, constants and helper functions of the time-of-day alarm table.
package tda_pkg;

   // Table geometry.
   localparam int ENTRIES = 8;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Field widths.
   localparam int KEY_W  = 16;
   localparam int TIME_W = 12;
   localparam int HOUR_W = 5;
   localparam int MIN_W  = 6;

   // Time constants in hhmm form.
   localparam logic [TIME_W-1:0] DAY_END     = 12'd2400;
   localparam logic [TIME_W-1:0] HOUR_SCALE  = 12'd100;

   // Request opcodes.
   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   // Register bus.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ENABLE = 1'b0;

   // Request and result payloads.
   typedef struct packed {
      logic [1:0]        op;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] alarm_time;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] fired_key;
      logic             last;
   } rsp_type;

   // What a request does once decoded.
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_SET,
      ACT_REMOVE,
      ACT_UPDATE
   } act_type;

   // Token that walks the chain of slot cells.
   typedef struct packed {
      logic              valid;
      act_type           act;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] atime;
      logic [TIME_W-1:0] cur;
      logic [TIME_W-1:0] prev;
      logic              match_found;
      logic [IDX_W-1:0]  match_idx;
      logic              empty_found;
      logic [IDX_W-1:0]  empty_idx;
      logic              pend_valid;
      logic [KEY_W-1:0]  pend_key;
   } tok_type;

   // Slot write broadcast from the controller.
   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] atime;
   } wr_type;

   // A fired key released by a cell.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } emit_type;

   // True when time t lies in (prev, cur], wrapping through the end of day.
   function automatic logic in_window(input logic [TIME_W-1:0] t,
                                      input logic [TIME_W-1:0] prev,
                                      input logic [TIME_W-1:0] cur);
      logic hit;
      if (prev < cur) begin
         hit = (t > prev) && (t <= cur);
      end else if (prev > cur) begin
         hit = ((t > prev) && (t < DAY_END)) || (t <= cur);
      end else begin
         hit = 1'b0;
      end
      return hit;
   endfunction

endpackage

// ===== design/tda_cell.sv =====
// One alarm slot of the table, with its stage of the token chain.
module tda_cell import tda_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic             advance,
   input  tok_type          tok_i,
   input  wr_type           wr,
   output tok_type          tok_o,
   output emit_type         emit
);

   logic [KEY_W-1:0]  slot_key_ff;
   logic [TIME_W-1:0] slot_time_ff;
   tok_type           tok_ff;
   tok_type           tok_in;
   logic              occupied;
   logic              hit;

   // Look at this slot as the token passes by.
   always_comb begin
      occupied = (slot_key_ff != '0);
      hit      = tok_i.valid && (tok_i.act == ACT_UPDATE) && occupied &&
                 in_window(slot_time_ff, tok_i.prev, tok_i.cur);
      tok_in   = tok_i;
      if (tok_i.act == ACT_SET || tok_i.act == ACT_REMOVE) begin
         if (!tok_i.match_found && (slot_key_ff == tok_i.key)) begin
            tok_in.match_found = 1'b1;
            tok_in.match_idx   = cell_idx;
         end
         // The highest empty slot wins, so later cells overwrite.
         if (!occupied) begin
            tok_in.empty_found = 1'b1;
            tok_in.empty_idx   = cell_idx;
         end
      end
      if (hit) begin
         tok_in.pend_valid = 1'b1;
         tok_in.pend_key   = slot_key_ff;
      end
   end

   // A new hit pushes out the key held so far; it cannot be the final one.
   assign emit.valid = hit && tok_i.pend_valid;
   assign emit.key   = tok_i.pend_key;
   assign tok_o      = tok_ff;

   // Token stage toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   // Slot contents, written by the controller when a request finishes.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_key_ff  <= '0;
         slot_time_ff <= '0;
      end else if (wr.valid && (wr.idx == cell_idx)) begin
         slot_key_ff  <= wr.key;
         slot_time_ff <= wr.atime;
      end
   end

endmodule

// ===== design/time_of_day_alarm_table_unit.sv =====
// Top level of the time-of-day alarm table: token controller, results and registers.
// Each request walks a chain of ENTRIES slot cells, one cell per cycle while the
// chain is not stalled, and finishes as it leaves the last cell. req_ready stays
// low until the request finishes, so a new request is taken only after the last
// one is through. A set or remove writes the chosen slot as it finishes. A clock
// update sends the keys of fired slots out in slot order, the last of them
// flagged; the chain stalls while the result register is full and not being read
// and another fired key is waiting, so slow result consumers hold it up.
// The enable register is sampled when a request is accepted.
module time_of_day_alarm_table_unit import tda_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

`include "assert_macros.svh"

   logic              enable_ff;
   logic              busy_ff;
   logic [TIME_W-1:0] prev_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   tok_type           tok_head;
   tok_type           tok_chain [0:ENTRIES];
   emit_type          cell_emit [ENTRIES];
   logic [ENTRIES-1:0] tok_valid_vec;
   tok_type           fin;
   wr_type            wr;
   act_type           req_act;
   logic [TIME_W-1:0] req_cur;
   logic              accept;
   logic              emit_any;
   logic [KEY_W-1:0]  emit_key;
   logic              finish_emit;
   logic              need_out;
   logic              out_free;
   logic              go;
   logic              finish;
   logic [IDX_W-1:0]  set_idx;

   // Register bus.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_ENABLE) ? {{(CSR_DATA_W-1){1'b0}}, enable_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ENABLE)) begin
         enable_ff <= pwdata[0];
      end
   end

   // Decode the request into an action for the chain.
   assign accept = req_valid && req_ready;
   assign req_cur = ({{(TIME_W-HOUR_W){1'b0}}, req_data.hour} * HOUR_SCALE) +
                    {{(TIME_W-MIN_W){1'b0}}, req_data.minute};

   always_comb begin
      case (req_data.op)
         OP_SET:    req_act = (req_data.key != '0) ? ACT_SET : ACT_NONE;
         OP_REMOVE: req_act = (req_data.key != '0) ? ACT_REMOVE : ACT_NONE;
         OP_UPDATE: req_act = enable_ff ? ACT_UPDATE : ACT_NONE;
         default:   req_act = ACT_NONE;
      endcase
   end

   // Token entering the first cell.
   always_comb begin
      tok_head             = '0;
      tok_head.valid       = accept;
      tok_head.act         = req_act;
      tok_head.key         = req_data.key;
      tok_head.atime       = req_data.alarm_time;
      tok_head.cur         = req_cur;
      tok_head.prev        = prev_ff;
   end

   assign tok_chain[0] = tok_head;

   // Chain of slot cells.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      tda_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .advance  (go),
         .tok_i    (tok_chain[i]),
         .wr       (wr),
         .tok_o    (tok_chain[i+1]),
         .emit     (cell_emit[i])
      );
      assign tok_valid_vec[i] = tok_chain[i+1].valid;
   end

   // Only the cell holding the token can release a key.
   always_comb begin
      emit_any = 1'b0;
      emit_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         emit_any = emit_any | cell_emit[i].valid;
         emit_key = emit_key | (cell_emit[i].valid ? cell_emit[i].key : '0);
      end
   end

   // Finishing step and stall control.
   assign fin         = tok_chain[ENTRIES];
   assign finish_emit = fin.valid && (fin.act == ACT_UPDATE) && fin.pend_valid;
   assign need_out    = emit_any || finish_emit;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign go          = !need_out || out_free;
   assign finish      = fin.valid && go;

   // Slot write for set and remove.
   always_comb begin
      if (fin.match_found) begin
         set_idx = fin.match_idx;
      end else if (fin.empty_found) begin
         set_idx = fin.empty_idx;
      end else begin
         set_idx = '0;
      end
      wr = '0;
      case (fin.act)
         ACT_SET: begin
            wr.valid = finish;
            wr.idx   = set_idx;
            wr.key   = fin.key;
            wr.atime = fin.atime;
         end
         ACT_REMOVE: begin
            wr.valid = finish && fin.match_found;
            wr.idx   = fin.match_idx;
         end
         default: begin
            wr.valid = 1'b0;
         end
      endcase
   end

   // Busy flag and previous time.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prev_ff <= DAY_END;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (finish && (fin.act == ACT_UPDATE)) begin
            prev_ff <= fin.cur;
         end
      end
   end

   assign req_ready = !busy_ff;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && need_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && need_out) begin
         rsp_data_ff.fired_key <= emit_any ? emit_key : fin.pend_key;
         rsp_data_ff.last      <= !emit_any;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the token chain.
   `ASSERT_ALWAYS(a_one_token, clock, reset, $onehot0(tok_valid_vec))
   `ASSERT_NEXT(a_accept_enters, clock, reset, accept, tok_valid_vec[0])
   `ASSERT_IMPLIES(a_idle_empty, clock, reset, !busy_ff, tok_valid_vec == '0)

endmodule
